// File: rtl/rau_pkg.sv
// Package for the rational arithmetic unit: command codes, widths, shared types.
// No dependencies.
package rau_pkg;
    localparam logic [2:0] CMD_ADD = 3'd0;
    localparam logic [2:0] CMD_SUB = 3'd1;
    localparam logic [2:0] CMD_MUL = 3'd2;
    localparam logic [2:0] CMD_DIV = 3'd3;
    localparam logic [2:0] CMD_CMP = 3'd4;
    localparam int WIDE_BITS = 64;
    typedef logic [WIDE_BITS-1:0] t_wide;
    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } t_div_ctl;
endpackage

// File: rtl/rational_arithmetic_unit.sv
// Rational arithmetic unit top level: operand products, binary GCD, reduction.
// Depends on rau_pkg and rau_divider.
// Compare, errors and unused commands go from the products straight to the output;
// arithmetic runs a binary GCD, then divides numerator and denominator by it in turn.
// One transaction at a time; the next is accepted once the result is in the output
// register. Synchronous active-low reset returns the sequencer to idle, output invalid.
module rational_arithmetic_unit #(
    parameter int OPERAND_BITS = 32
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic [2:0]              i_command,
    input  logic signed [OPERAND_BITS-1:0] i_left_numerator,
    input  logic [OPERAND_BITS-2:0] i_left_denominator,
    input  logic signed [OPERAND_BITS-1:0] i_right_numerator,
    input  logic [OPERAND_BITS-2:0] i_right_denominator,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic signed [63:0]      o_result_numerator,
    output logic [62:0]             o_result_denominator,
    output logic                    o_is_less,
    output logic                    o_is_equal,
    output logic                    o_is_greater,
    output logic                    o_divide_by_zero
);
    localparam logic [3:0] S_IDLE = 4'd0, S_MUL = 4'd1, S_COMB = 4'd2, S_GSH = 4'd3,
        S_GA = 4'd4, S_GB = 4'd5, S_GSUB = 4'd6, S_DIVN = 4'd7, S_WN = 4'd8,
        S_DIVD = 4'd9, S_WD = 4'd10, S_OUT = 4'd11;
    localparam int ShBits = 7;

    logic [3:0] r_state, n_state;
    logic [2:0] r_cmd;
    logic signed [OPERAND_BITS-1:0] r_ln, r_ld, r_rn, r_rd;
    logic signed [63:0] r_p1, r_p2, r_p3;
    rau_pkg::t_wide r_mn, r_md, r_a, r_b;
    logic r_neg;
    logic [ShBits-1:0] r_sh;
    logic signed [63:0] r_onum;
    logic [62:0] r_oden;
    logic r_lt, r_eq, r_gt, r_dz, r_ovalid;
    logic signed [63:0] r_res_num;
    logic [62:0] r_res_den;
    logic r_res_lt, r_res_eq, r_res_gt, r_res_dz;
    logic w_take;
    logic w_out_load;
    logic signed [63:0] w_num, w_den;
    rau_pkg::t_wide w_gcd, w_dvd;
    logic w_dstart;
    rau_pkg::t_div_ctl w_dctl;
    rau_pkg::t_wide w_q;

    assign w_take = i_valid && !o_stall;
    assign o_stall = (r_state != S_IDLE);
    assign w_out_load = (r_state == S_OUT) && (!r_ovalid || !i_stall);
    assign w_gcd = r_a << r_sh;
    assign w_dstart = (r_state == S_GSUB && r_b == '0);
    assign w_dvd = (r_state == S_WN && w_dctl.done) ? r_md : r_mn;

    rau_divider u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_start(w_dstart || (r_state == S_WN && w_dctl.done)),
        .i_dividend(w_dvd), .i_divisor(w_gcd),
        .o_ctl(w_dctl), .o_quotient(w_q)
    );

    always_comb begin
        w_num = 64'sd0;
        w_den = r_p3;
        unique case (r_cmd)
            rau_pkg::CMD_ADD: w_num = r_p1 + r_p2;
            rau_pkg::CMD_SUB: w_num = r_p1 - r_p2;
            rau_pkg::CMD_MUL: w_num = r_p3;
            default:          w_num = r_p1;
        endcase
        if (r_cmd == rau_pkg::CMD_MUL) w_den = r_p2;
        else if (r_cmd == rau_pkg::CMD_DIV) w_den = r_p2;
        else w_den = r_p3;
        if (r_cmd == rau_pkg::CMD_DIV && r_p2 < 0) begin
            w_num = -w_num;
            w_den = -w_den;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (w_take) n_state = S_MUL;
            S_MUL:  n_state = S_COMB;
            S_COMB: n_state = (r_dz || r_cmd == rau_pkg::CMD_CMP || r_cmd > rau_pkg::CMD_CMP)
                        ? S_OUT : S_GSH;
            S_GSH:  n_state = (r_a == '0 || r_b == '0 || ((r_a | r_b) & 64'd1) != '0)
                        ? S_GA : S_GSH;
            S_GA:   n_state = (r_a[0] || r_b == '0) ? S_GB : S_GA;
            S_GB:   n_state = (r_b[0] || r_b == '0) ? S_GSUB : S_GB;
            S_GSUB: n_state = (r_b == '0) ? S_DIVN : S_GB;
            S_DIVN: n_state = S_WN;
            S_WN:   if (w_dctl.done) n_state = S_WD;
            S_WD:   if (w_dctl.done) n_state = S_OUT;
            S_OUT:  if (w_out_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_out_load) r_ovalid <= 1'b1;
            else if (r_ovalid && !i_stall) r_ovalid <= 1'b0;
        end
        unique case (r_state)
            S_IDLE: if (w_take) begin
                r_cmd <= i_command;
                r_ln <= i_left_numerator;
                r_rn <= i_right_numerator;
                r_ld <= {1'b0, i_left_denominator};
                r_rd <= {1'b0, i_right_denominator};
            end
            S_MUL: begin
                r_p1 <= 64'(r_ln) * 64'(r_rd);
                r_p2 <= (r_cmd == rau_pkg::CMD_MUL) ? 64'(r_ld) * 64'(r_rd)
                                                    : 64'(r_rn) * 64'(r_ld);
                r_p3 <= (r_cmd == rau_pkg::CMD_MUL) ? 64'(r_ln) * 64'(r_rn)
                                                    : 64'(r_ld) * 64'(r_rd);
                r_dz <= (r_ld == 0 || r_rd == 0 || (r_cmd == rau_pkg::CMD_DIV && r_rn == 0))
                        && r_cmd <= rau_pkg::CMD_CMP;
            end
            S_COMB: begin
                r_neg <= w_num < 0;
                r_mn <= w_num < 0 ? rau_pkg::t_wide'(-w_num) : rau_pkg::t_wide'(w_num);
                r_md <= rau_pkg::t_wide'(w_den);
                r_a <= w_num < 0 ? rau_pkg::t_wide'(-w_num) : rau_pkg::t_wide'(w_num);
                r_b <= rau_pkg::t_wide'(w_den);
                r_sh <= '0;
                r_lt <= r_cmd == rau_pkg::CMD_CMP && !r_dz && r_p1 < r_p2;
                r_eq <= r_cmd == rau_pkg::CMD_CMP && !r_dz && r_p1 == r_p2;
                r_gt <= r_cmd == rau_pkg::CMD_CMP && !r_dz && r_p1 > r_p2;
                r_onum <= '0;
                r_oden <= '0;
            end
            S_GSH: if (!(r_a == '0 || r_b == '0 || ((r_a | r_b) & 64'd1) != '0)) begin
                r_a <= r_a >> 1;
                r_b <= r_b >> 1;
                r_sh <= r_sh + 1'b1;
            end else if (r_a == '0) begin
                r_a <= r_b;
                r_b <= '0;
            end
            S_GA: if (!(r_a[0] || r_b == '0)) r_a <= r_a >> 1;
            S_GB: if (!(r_b[0] || r_b == '0)) r_b <= r_b >> 1;
            S_GSUB: if (r_b != '0) begin
                if (r_a > r_b) begin
                    r_a <= r_b;
                    r_b <= r_a - r_b;
                end else begin
                    r_b <= r_b - r_a;
                end
            end
            S_WN: if (w_dctl.done) r_onum <= r_neg ? -$signed(w_q) : $signed(w_q);
            S_WD: if (w_dctl.done) r_oden <= w_q[62:0];
            S_OUT: if (w_out_load) begin
                r_res_num <= r_onum;
                r_res_den <= r_oden;
                r_res_lt <= r_lt;
                r_res_eq <= r_eq;
                r_res_gt <= r_gt;
                r_res_dz <= r_dz;
            end
            default: ;
        endcase
    end

    assign o_valid = r_ovalid;
    assign o_result_numerator = r_res_num;
    assign o_result_denominator = r_res_den;
    assign o_is_less = r_res_lt;
    assign o_is_equal = r_res_eq;
    assign o_is_greater = r_res_gt;
    assign o_divide_by_zero = r_res_dz;

    a_one_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $countones({o_is_less, o_is_equal, o_is_greater, o_divide_by_zero}) <= 1)
        else $error("more than one outcome flag");
    a_busy_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> o_stall)
        else $error("accepting while busy");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_result_numerator)))
        else $error("stalled result changed");
endmodule

// File: rtl/rau_divider.sv
// Restoring divider, one quotient bit per cycle, for 64-bit unsigned operands.
// Depends on rau_pkg.
module rau_divider (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  rau_pkg::t_wide i_dividend,
    input  rau_pkg::t_wide i_divisor,
    output rau_pkg::t_div_ctl o_ctl,
    output rau_pkg::t_wide o_quotient
);
    localparam int CntBits = $clog2(rau_pkg::WIDE_BITS + 1);
    logic [CntBits-1:0] r_cnt, n_cnt;
    rau_pkg::t_wide r_quo, n_quo, r_rem, n_rem, r_den;
    logic [rau_pkg::WIDE_BITS:0] w_trial;
    logic r_busy, n_busy, r_done, n_done;

    always_comb begin
        n_cnt = r_cnt;
        n_quo = r_quo;
        n_rem = r_rem;
        n_busy = r_busy;
        n_done = 1'b0;
        w_trial = {r_rem, r_quo[rau_pkg::WIDE_BITS-1]} - {1'b0, r_den};
        if (i_start) begin
            n_cnt = CntBits'(rau_pkg::WIDE_BITS);
            n_quo = i_dividend;
            n_rem = '0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (!w_trial[rau_pkg::WIDE_BITS]) begin
                n_rem = w_trial[rau_pkg::WIDE_BITS-1:0];
                n_quo = {r_quo[rau_pkg::WIDE_BITS-2:0], 1'b1};
            end else begin
                n_rem = {r_rem[rau_pkg::WIDE_BITS-2:0], r_quo[rau_pkg::WIDE_BITS-1]};
                n_quo = {r_quo[rau_pkg::WIDE_BITS-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CntBits'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt <= n_cnt;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        if (i_start) r_den <= i_divisor;
    end

    assign o_ctl = '{start: i_start, busy: r_busy, done: r_done};
    assign o_quotient = r_quo;
endmodule
